// ===== design/sfcs_pkg.sv =====
// shared types, codes and constants of the spi flash command sequencer
package sfcs_pkg;

	localparam int unsigned PAGE_BYTES = 256;
	localparam int unsigned MAX_RES = 12;
	localparam int unsigned CNT_W = $clog2(MAX_RES + 1);
	localparam int unsigned IDX_W = $clog2(MAX_RES);

	// request and byte codes on the input side
	localparam logic [2:0] CMD_ID       = 3'd0;
	localparam logic [2:0] CMD_STATUS   = 3'd1;
	localparam logic [2:0] CMD_WREN     = 3'd2;
	localparam logic [2:0] CMD_READ     = 3'd3;
	localparam logic [2:0] CMD_PROG     = 3'd4;
	localparam logic [2:0] CMD_ERASE    = 3'd5;
	localparam logic [2:0] CMD_PAYLOAD  = 3'd6;
	localparam logic [2:0] CMD_RETURNED = 3'd7;

	// bus actions on the output side
	localparam logic [2:0] ACT_CS_LOW  = 3'd0;
	localparam logic [2:0] ACT_SEND    = 3'd1;
	localparam logic [2:0] ACT_SLOT    = 3'd2;
	localparam logic [2:0] ACT_CS_HIGH = 3'd3;
	localparam logic [2:0] ACT_HOST    = 3'd4;
	localparam logic [2:0] ACT_DONE    = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REJECT  = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// flash opcodes
	localparam logic [7:0] OPC_RDID  = 8'h9F;
	localparam logic [7:0] OPC_RDSR  = 8'h05;
	localparam logic [7:0] OPC_WREN  = 8'h06;
	localparam logic [7:0] OPC_READ  = 8'h03;
	localparam logic [7:0] OPC_PP    = 8'h02;
	localparam logic [7:0] OPC_SE    = 8'h20;

	// register map, selected by paddr[2]
	localparam logic REG_PROG_LIMIT  = 1'b0;
	localparam logic REG_ERASE_LIMIT = 1'b1;

	localparam logic [23:0] PROG_LIMIT_RST  = 24'd1000000;
	localparam logic [23:0] ERASE_LIMIT_RST = 24'd10000000;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ID,
		PH_STAT,
		PH_READ,
		PH_PAY,
		PH_POLL
	} phase_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [23:0] address;
		logic [15:0] length;
		logic [7:0]  data_byte;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  bus_byte;
		logic [23:0] value;
		logic [1:0]  status;
		logic        last;
	} res_item_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] bus_byte;
	} ent_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  current_op;
		logic [15:0] bytes_left;
		logic [23:0] polls_done;
		logic [23:0] id_acc;
	} ctx_t;

	typedef struct packed {
		ent_t [MAX_RES-1:0] ent;
		logic [CNT_W-1:0]   cnt;
		logic [23:0]        value;
		logic [1:0]         status;
	} dec_t;

	function automatic ent_t mk(input logic [2:0] act, input logic [7:0] b);
		ent_t e;
		e.action = act;
		e.bus_byte = b;
		return e;
	endfunction

endpackage

// ===== design/sfcs_decode.sv =====
// expands one item against the current state into its list of bus actions
module sfcs_decode (
	input  sfcs_pkg::req_item_t item,
	input  sfcs_pkg::ctx_t      st,
	input  logic [23:0]         prog_lim,
	input  logic [23:0]         erase_lim,
	output sfcs_pkg::dec_t      dec,
	output sfcs_pkg::ctx_t      nxt
);
	import sfcs_pkg::*;

	logic [23:0] lim;
	logic [15:0] bl_dec;
	logic [23:0] polls_inc;
	logic [23:0] id_new;
	logic [16:0] page_end;
	logic        prog_bad;

	always_comb begin
		lim = (st.current_op == CMD_ERASE) ? erase_lim : prog_lim;
		bl_dec = st.bytes_left - 16'd1;
		polls_inc = st.polls_done + 24'd1;
		id_new = {st.id_acc[15:0], item.data_byte};
		page_end = 17'(item.address % PAGE_BYTES) + {1'b0, item.length};
		prog_bad = (item.length == 16'd0) || ({1'b0, item.length} > 17'(PAGE_BYTES)) ||
			(page_end > 17'(PAGE_BYTES));

		dec = '0;
		nxt = st;

		if ((item.cmd inside {[CMD_ID:CMD_ERASE]}) && st.phase != PH_IDLE) begin
			dec.ent[0] = mk(ACT_DONE, 8'h00);
			dec.status = ST_REJECT;
			dec.cnt = CNT_W'(1);
		end else begin
			case (item.cmd)
				CMD_ID: begin
					dec.ent[0] = mk(ACT_CS_LOW, 8'h00);
					dec.ent[1] = mk(ACT_SEND, OPC_RDID);
					dec.ent[2] = mk(ACT_SLOT, 8'h00);
					dec.cnt = CNT_W'(3);
					nxt.id_acc = '0;
					nxt.bytes_left = 16'd3;
					nxt.phase = PH_ID;
				end
				CMD_STATUS: begin
					dec.ent[0] = mk(ACT_CS_LOW, 8'h00);
					dec.ent[1] = mk(ACT_SEND, OPC_RDSR);
					dec.ent[2] = mk(ACT_SLOT, 8'h00);
					dec.cnt = CNT_W'(3);
					nxt.phase = PH_STAT;
				end
				CMD_WREN: begin
					dec.ent[0] = mk(ACT_CS_LOW, 8'h00);
					dec.ent[1] = mk(ACT_SEND, OPC_WREN);
					dec.ent[2] = mk(ACT_CS_HIGH, 8'h00);
					dec.ent[3] = mk(ACT_DONE, 8'h00);
					dec.cnt = CNT_W'(4);
				end
				CMD_READ: begin
					dec.ent[0] = mk(ACT_CS_LOW, 8'h00);
					dec.ent[1] = mk(ACT_SEND, OPC_READ);
					dec.ent[2] = mk(ACT_SEND, item.address[23:16]);
					dec.ent[3] = mk(ACT_SEND, item.address[15:8]);
					dec.ent[4] = mk(ACT_SEND, item.address[7:0]);
					if (item.length == 16'd0) begin
						dec.ent[5] = mk(ACT_CS_HIGH, 8'h00);
						dec.ent[6] = mk(ACT_DONE, 8'h00);
						dec.cnt = CNT_W'(7);
					end else begin
						dec.ent[5] = mk(ACT_SLOT, 8'h00);
						dec.cnt = CNT_W'(6);
						nxt.bytes_left = item.length;
						nxt.phase = PH_READ;
					end
				end
				CMD_PROG: begin
					if (prog_bad) begin
						dec.ent[0] = mk(ACT_DONE, 8'h00);
						dec.status = ST_REJECT;
						dec.cnt = CNT_W'(1);
					end else begin
						dec.ent[0] = mk(ACT_CS_LOW, 8'h00);
						dec.ent[1] = mk(ACT_SEND, OPC_WREN);
						dec.ent[2] = mk(ACT_CS_HIGH, 8'h00);
						dec.ent[3] = mk(ACT_CS_LOW, 8'h00);
						dec.ent[4] = mk(ACT_SEND, OPC_PP);
						dec.ent[5] = mk(ACT_SEND, item.address[23:16]);
						dec.ent[6] = mk(ACT_SEND, item.address[15:8]);
						dec.ent[7] = mk(ACT_SEND, item.address[7:0]);
						dec.cnt = CNT_W'(8);
						nxt.current_op = CMD_PROG;
						nxt.bytes_left = item.length;
						nxt.phase = PH_PAY;
					end
				end
				CMD_ERASE: begin
					// address masked to its 4 KiB sector
					dec.ent[0] = mk(ACT_CS_LOW, 8'h00);
					dec.ent[1] = mk(ACT_SEND, OPC_WREN);
					dec.ent[2] = mk(ACT_CS_HIGH, 8'h00);
					dec.ent[3] = mk(ACT_CS_LOW, 8'h00);
					dec.ent[4] = mk(ACT_SEND, OPC_SE);
					dec.ent[5] = mk(ACT_SEND, item.address[23:16]);
					dec.ent[6] = mk(ACT_SEND, {item.address[15:12], 4'h0});
					dec.ent[7] = mk(ACT_SEND, 8'h00);
					dec.ent[8] = mk(ACT_CS_HIGH, 8'h00);
					nxt.current_op = CMD_ERASE;
					nxt.polls_done = '0;
					if (erase_lim == 24'd0) begin
						dec.ent[9] = mk(ACT_DONE, 8'h00);
						dec.status = ST_TIMEOUT;
						dec.cnt = CNT_W'(10);
					end else begin
						dec.ent[9] = mk(ACT_CS_LOW, 8'h00);
						dec.ent[10] = mk(ACT_SEND, OPC_RDSR);
						dec.ent[11] = mk(ACT_SLOT, 8'h00);
						dec.cnt = CNT_W'(12);
						nxt.phase = PH_POLL;
					end
				end
				CMD_PAYLOAD: begin
					if (st.phase == PH_PAY) begin
						dec.ent[0] = mk(ACT_SEND, item.data_byte);
						dec.cnt = CNT_W'(1);
						nxt.bytes_left = bl_dec;
						if (bl_dec == 16'd0) begin
							dec.ent[1] = mk(ACT_CS_HIGH, 8'h00);
							nxt.polls_done = '0;
							if (lim == 24'd0) begin
								dec.ent[2] = mk(ACT_DONE, 8'h00);
								dec.status = ST_TIMEOUT;
								dec.cnt = CNT_W'(3);
								nxt.phase = PH_IDLE;
							end else begin
								dec.ent[2] = mk(ACT_CS_LOW, 8'h00);
								dec.ent[3] = mk(ACT_SEND, OPC_RDSR);
								dec.ent[4] = mk(ACT_SLOT, 8'h00);
								dec.cnt = CNT_W'(5);
								nxt.phase = PH_POLL;
							end
						end
					end
				end
				CMD_RETURNED: begin
					case (st.phase)
						PH_ID: begin
							nxt.id_acc = id_new;
							nxt.bytes_left = bl_dec;
							if (bl_dec == 16'd0) begin
								dec.ent[0] = mk(ACT_CS_HIGH, 8'h00);
								dec.ent[1] = mk(ACT_DONE, 8'h00);
								dec.value = id_new;
								dec.cnt = CNT_W'(2);
								nxt.phase = PH_IDLE;
							end else begin
								dec.ent[0] = mk(ACT_SLOT, 8'h00);
								dec.cnt = CNT_W'(1);
							end
						end
						PH_STAT: begin
							dec.ent[0] = mk(ACT_CS_HIGH, 8'h00);
							dec.ent[1] = mk(ACT_DONE, 8'h00);
							dec.value = {16'h0000, item.data_byte};
							dec.cnt = CNT_W'(2);
							nxt.phase = PH_IDLE;
						end
						PH_READ: begin
							dec.ent[0] = mk(ACT_HOST, item.data_byte);
							nxt.bytes_left = bl_dec;
							if (bl_dec == 16'd0) begin
								dec.ent[1] = mk(ACT_CS_HIGH, 8'h00);
								dec.ent[2] = mk(ACT_DONE, 8'h00);
								dec.cnt = CNT_W'(3);
								nxt.phase = PH_IDLE;
							end else begin
								dec.ent[1] = mk(ACT_SLOT, 8'h00);
								dec.cnt = CNT_W'(2);
							end
						end
						PH_POLL: begin
							dec.ent[0] = mk(ACT_CS_HIGH, 8'h00);
							nxt.polls_done = polls_inc;
							if (!item.data_byte[0]) begin
								dec.ent[1] = mk(ACT_DONE, 8'h00);
								dec.value = {16'h0000, item.data_byte};
								dec.cnt = CNT_W'(2);
								nxt.phase = PH_IDLE;
							end else if (polls_inc >= lim) begin
								dec.ent[1] = mk(ACT_DONE, 8'h00);
								dec.value = {16'h0000, item.data_byte};
								dec.status = ST_TIMEOUT;
								dec.cnt = CNT_W'(2);
								nxt.phase = PH_IDLE;
							end else begin
								dec.ent[1] = mk(ACT_CS_LOW, 8'h00);
								dec.ent[2] = mk(ACT_SEND, OPC_RDSR);
								dec.ent[3] = mk(ACT_SLOT, 8'h00);
								dec.cnt = CNT_W'(4);
							end
						end
						default: begin
							// stray returned byte: nothing to do
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== design/spi_flash_command_sequencer_core.sv =====
// top level of the spi flash command sequencer: input stage, state, action list and apb registers
// an accepted item is held in the input register, then its decoded actions in the action list
// throughput: one result per cycle unless res_stall holds it; each item loads its results,
// up to 12 for a sector erase that starts polling, into the action list
// the next item waits in the input register while the action list drains
// reset: arst_n clears the state to idle and the poll limits to 1000000 and 10000000
module spi_flash_command_sequencer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_stall,
	input  sfcs_pkg::req_item_t req,
	output logic                res_valid,
	input  logic                res_stall,
	output sfcs_pkg::res_item_t res
);
	import sfcs_pkg::*;

	logic [23:0]        prog_lim_q;
	logic [23:0]        erase_lim_q;
	logic               valid_s1;
	req_item_t          item_s1;
	ctx_t               ctx_q;
	ctx_t               ctx_nxt;
	dec_t               dec;
	ent_t [MAX_RES-1:0] ent_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   rem_q;
	logic [23:0]        val_q;
	logic [1:0]         st_q;
	logic               res_take;
	logic               load;
	logic               cfg_wr;
	ent_t               head;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_lim_q <= PROG_LIMIT_RST;
			erase_lim_q <= ERASE_LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PROG_LIMIT:  prog_lim_q <= pwdata[23:0];
				REG_ERASE_LIMIT: erase_lim_q <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PROG_LIMIT:  prdata = {8'h00, prog_lim_q};
			REG_ERASE_LIMIT: prdata = {8'h00, erase_lim_q};
			default:         prdata = '0;
		endcase
	end

	// the list may be replaced once its final action is taken, or whenever it is empty
	assign res_take = res_valid && !res_stall;
	assign load = valid_s1 && ((rem_q == '0) || (rem_q == CNT_W'(1) && res_take));
	assign req_stall = valid_s1 && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	sfcs_decode u_decode (
		.item      (item_s1),
		.st        (ctx_q),
		.prog_lim  (prog_lim_q),
		.erase_lim (erase_lim_q),
		.dec       (dec),
		.nxt       (ctx_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{phase: PH_IDLE, default: '0};
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			ctx_q <= ctx_nxt;
			rem_q <= dec.cnt;
			idx_q <= '0;
		end else if (res_take) begin
			rem_q <= rem_q - CNT_W'(1);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= dec.ent;
			val_q <= dec.value;
			st_q <= dec.status;
		end
	end

	// value and status belong to the done action, which is always the last action of its list
	always_comb begin
		head = ent_q[idx_q];
		res_valid = (rem_q != '0);
		res.action = head.action;
		res.bus_byte = head.bus_byte;
		res.value = (head.action == ACT_DONE) ? val_q : 24'h000000;
		res.status = (head.action == ACT_DONE) ? st_q : ST_OK;
		res.last = (rem_q == CNT_W'(1));
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CNT_W'(MAX_RES))
		else $error("action count beyond list size");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.action == ACT_DONE |-> res.last)
		else $error("done action not at end of list");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && res.last && !valid_s1 |=> !res_valid)
		else $error("result shown after list drained");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.action != ACT_DONE |-> res.value == 24'h000000 && res.status == ST_OK)
		else $error("value or status set on a non-done action");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rem_q == $past(dec.cnt))
		else $error("list count lost on load");

endmodule
